### rtl/core/umtc_pkg.sv
// ----------------------------------------------------------------------------
// umtc_pkg
// Shared types and codes for the up/down motor timeout controller.
// ----------------------------------------------------------------------------
package umtc_pkg;

    localparam int unsigned FLAG_W  = 9;
    localparam int unsigned COUNT_W = 18;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned CODE_W  = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd30000;

    // external motor_mode codes
    localparam logic [CODE_W-1:0] MODE_CODE_STOP = 2'd0;
    localparam logic [CODE_W-1:0] MODE_CODE_UP   = 2'd1;
    localparam logic [CODE_W-1:0] MODE_CODE_DOWN = 2'd2;

    // item kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_STOP = 3'b001,
        ST_UP   = 3'b010,
        ST_DOWN = 3'b100
    } t_motor_state;

    typedef struct packed {
        logic               req_type;
        logic [FLAG_W-1:0]  first_reading;
        logic [FLAG_W-1:0]  second_reading;
    } t_item;

    typedef struct packed {
        logic [FLAG_W-1:0]  flags;
        t_motor_state       motor_mode;
        logic [COUNT_W-1:0] motor_elapsed;
        logic               screen_running;
        logic [COUNT_W-1:0] screen_elapsed;
    } t_state;

endpackage

### rtl/core/umtc_step.sv
// ----------------------------------------------------------------------------
// umtc_step
// Next-state logic for one item: debounce, motor state machine, screen latch
// and the two timeout counters.
// ----------------------------------------------------------------------------
module umtc_step (
    input  umtc_pkg::t_item              i_item,
    input  umtc_pkg::t_state             i_state,
    input  logic [umtc_pkg::STEP_W-1:0]  i_step,
    output umtc_pkg::t_state             o_state
);
    import umtc_pkg::*;

    // (k+1) * step using shifts and one add
    function automatic logic [COUNT_W-1:0] limit_for(
        input logic [1:0]        k,
        input logic [STEP_W-1:0] step
    );
        logic [COUNT_W-1:0] one_x;
        logic [COUNT_W-1:0] two_x;
        logic [COUNT_W-1:0] res;
        one_x = {2'b00, step};
        two_x = {1'b0, step, 1'b0};
        case (k)
            2'd0:    res = one_x;
            2'd1:    res = two_x;
            2'd2:    res = one_x + two_x;
            default: res = {step, 2'b00};
        endcase
        return res;
    endfunction

    logic [FLAG_W-1:0]  diff;
    logic [4:0]         agree;
    logic [FLAG_W-1:0]  new_flags;
    logic               up, dn, scr, top, bot;
    logic [COUNT_W-1:0] motor_inc;
    logic [COUNT_W-1:0] screen_inc;
    logic [COUNT_W-1:0] motor_limit;
    logic [COUNT_W-1:0] screen_limit;
    t_motor_state       go_mode;
    logic               go, stop;

    always_comb begin
        diff      = i_item.first_reading ^ i_item.second_reading;
        agree     = ~diff[4:0];
        new_flags = i_state.flags;
        new_flags[4:0] = (i_state.flags[4:0] & ~agree) | (i_item.second_reading[4:0] & agree);
        // select group is taken only when all four bits are stable
        if (diff[8:5] == 4'd0) begin
            new_flags[8:5] = i_item.second_reading[8:5];
        end
        up  = new_flags[0];
        dn  = new_flags[1];
        scr = new_flags[2];
        top = new_flags[3];
        bot = new_flags[4];
    end

    always_comb begin
        motor_inc    = i_state.motor_elapsed + COUNT_W'(1);
        screen_inc   = i_state.screen_elapsed + COUNT_W'(1);
        motor_limit  = limit_for(i_state.flags[6:5], i_step);
        screen_limit = limit_for(i_state.flags[8:7], i_step);
    end

    // motor decision on a sample
    always_comb begin
        go      = 1'b0;
        stop    = 1'b0;
        go_mode = ST_UP;
        if (up && dn) begin
            stop = 1'b1;
        end else if (up) begin
            stop    = top;
            go      = !top;
            go_mode = ST_UP;
        end else if (dn) begin
            stop    = bot;
            go      = !bot;
            go_mode = ST_DOWN;
        end else begin
            unique case (i_state.motor_mode)
                ST_UP:   stop = top;
                ST_DOWN: stop = bot;
                ST_STOP: stop = 1'b1;
                default: stop = 1'b1;
            endcase
        end
    end

    always_comb begin
        o_state = i_state;
        if (i_item.req_type == REQ_TICK) begin
            if (i_state.motor_mode != ST_STOP) begin
                if (motor_inc >= motor_limit) begin
                    o_state.motor_mode    = ST_STOP;
                    o_state.motor_elapsed = '0;
                end else begin
                    o_state.motor_elapsed = motor_inc;
                end
            end
            if (i_state.screen_running) begin
                if (screen_inc >= screen_limit) begin
                    o_state.screen_running = 1'b0;
                    o_state.screen_elapsed = '0;
                end else begin
                    o_state.screen_elapsed = screen_inc;
                end
            end
        end else begin
            o_state.flags = new_flags;
            if (stop) begin
                o_state.motor_mode    = ST_STOP;
                o_state.motor_elapsed = '0;
            end else if (go && (i_state.motor_mode != go_mode)) begin
                // count restarts only on a change of direction
                o_state.motor_mode    = go_mode;
                o_state.motor_elapsed = '0;
            end
            if (scr && !i_state.screen_running) begin
                o_state.screen_running = 1'b1;
                o_state.screen_elapsed = '0;
            end
        end
    end

endmodule

### rtl/core/updown_motor_timeout_controller_top.sv
// ----------------------------------------------------------------------------
// updown_motor_timeout_controller_top
// Up/down motor and screen motor controller with debounced inputs and
// millisecond run-time limits.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | req_type, first/second reading
//  out     | output    | o_out_valid / i_out_ready | drive_up/down/screen, motor_mode
//  cfg     | input     | i_cfg_valid / o_cfg_ready | timeout_step_ticks
//
//  One item per cycle while the output is not stalled; an item passes the input
//  register, then the state update and result register in the same edge.
//  Synchronous active-low reset; step register resets to 30000 ticks.
//  A stalled output holds the result; the input register still takes a new
//  item when the result is taken in the same cycle.
// ----------------------------------------------------------------------------
module updown_motor_timeout_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [umtc_pkg::FLAG_W-1:0]   i_first_reading,
    input  logic [umtc_pkg::FLAG_W-1:0]   i_second_reading,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_drive_up,
    output logic                          o_drive_down,
    output logic                          o_drive_screen,
    output logic [umtc_pkg::CODE_W-1:0]   o_motor_mode,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [umtc_pkg::STEP_W-1:0]   i_cfg_timeout_step_ticks
);
    import umtc_pkg::*;

    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    logic               r_drive_up, r_drive_down, r_drive_screen;
    logic [CODE_W-1:0]  r_motor_mode;
    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step;
    logic               advance;
    logic [CODE_W-1:0]  n_code;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    umtc_step u_step (
        .i_item  (r_item),
        .i_state (r_state),
        .i_step  (r_step),
        .o_state (n_state)
    );

    always_comb begin
        unique case (n_state.motor_mode)
            ST_UP:   n_code = MODE_CODE_UP;
            ST_DOWN: n_code = MODE_CODE_DOWN;
            ST_STOP: n_code = MODE_CODE_STOP;
            default: n_code = MODE_CODE_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= STEP_RESET;
            r_state     <= '{flags: '0, motor_mode: ST_STOP, motor_elapsed: '0,
                             screen_running: 1'b0, screen_elapsed: '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_step <= i_cfg_timeout_step_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{req_type: i_req_type, first_reading: i_first_reading,
                        second_reading: i_second_reading};
        end
        if (advance) begin
            r_drive_up     <= (n_state.motor_mode == ST_UP);
            r_drive_down   <= (n_state.motor_mode == ST_DOWN);
            r_drive_screen <= n_state.screen_running;
            r_motor_mode   <= n_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_up     = r_drive_up;
    assign o_drive_down   = r_drive_down;
    assign o_drive_screen = r_drive_screen;
    assign o_motor_mode   = r_motor_mode;

`ifndef SYNTHESIS
    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_up && o_drive_down))
        else $error("both motor drives active");

    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motor_mode == MODE_CODE_STOP || o_motor_mode == MODE_CODE_UP
                         || o_motor_mode == MODE_CODE_DOWN))
        else $error("bad motor mode code");

    a_motor_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.motor_mode == ST_STOP) |-> (r_state.motor_elapsed == '0))
        else $error("stopped motor with nonzero count");

    a_screen_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.screen_running |-> (r_state.screen_elapsed == '0))
        else $error("idle screen with nonzero count");
`endif

endmodule

### dv/umtc_checker.sv
// ----------------------------------------------------------------------------
// umtc_checker
// Watches the item, result and step-register channels of the up/down motor
// timeout controller, predicts the drives for every accepted item and
// compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module umtc_checker
    import umtc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_req_type,
    input  logic [FLAG_W-1:0]   i_first_reading,
    input  logic [FLAG_W-1:0]   i_second_reading,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_drive_up,
    input  logic                i_drive_down,
    input  logic                i_drive_screen,
    input  logic [CODE_W-1:0]   i_motor_mode,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [STEP_W-1:0]   i_cfg_step,
    output int unsigned         o_mismatches,
    output int unsigned         o_drives_owed,
    output int unsigned         o_drives_checked,
    output int unsigned         o_timeout_stops
);
    timeunit 1ns;
    timeprecision 1ps;

    // debounced flag positions
    localparam int BIT_UP     = 0;
    localparam int BIT_DOWN   = 1;
    localparam int BIT_SCREEN = 2;
    localparam int BIT_TOP    = 3;
    localparam int BIT_BOTTOM = 4;

    typedef struct packed {
        logic              up;
        logic              down;
        logic              screen;
        logic [CODE_W-1:0] mode;
    } t_drives;

    logic [FLAG_W-1:0]  flags;
    logic [CODE_W-1:0]  mode;
    logic [COUNT_W-1:0] motor_cnt;
    logic               screen_on;
    logic [COUNT_W-1:0] screen_cnt;
    logic [STEP_W-1:0]  step_ticks;
    t_drives            expected_drives_q[$];
    int unsigned        mismatches     = 0;
    int unsigned        drives_checked = 0;
    int unsigned        timeout_stops  = 0;

    function automatic void stop_motor();
        mode      = MODE_CODE_STOP;
        motor_cnt = '0;
    endfunction

    // count restarts only on a change of direction
    function automatic void run_motor(logic [CODE_W-1:0] dir);
        if (mode != dir) begin
            motor_cnt = '0;
            mode      = dir;
        end
    endfunction

    function automatic t_drives apply_motor_item(logic kind, logic [FLAG_W-1:0] a,
                                                 logic [FLAG_W-1:0] b);
        logic [FLAG_W-1:0] agree;
        logic [31:0]       motor_lim;
        logic [31:0]       screen_lim;
        t_drives           d;
        if (kind == REQ_TICK) begin
            // limits use the select and step current at this tick
            motor_lim  = (32'(flags[6:5]) + 32'd1) * 32'(step_ticks);
            screen_lim = (32'(flags[8:7]) + 32'd1) * 32'(step_ticks);
            if (mode != MODE_CODE_STOP) begin
                motor_cnt = motor_cnt + 1'b1;
                if (32'(motor_cnt) >= motor_lim) begin
                    stop_motor();
                    timeout_stops++;
                end
            end
            if (screen_on) begin
                screen_cnt = screen_cnt + 1'b1;
                if (32'(screen_cnt) >= screen_lim) begin
                    screen_on  = 1'b0;
                    screen_cnt = '0;
                    timeout_stops++;
                end
            end
        end else begin
            agree = ~(a ^ b) & 9'h01F;
            flags = (flags & ~agree) | (b & agree);
            // select bits move only as a group
            if ((a[8:5] ^ b[8:5]) == 4'd0) flags[8:5] = b[8:5];

            if (flags[BIT_UP] && flags[BIT_DOWN]) begin
                stop_motor();
            end else if (flags[BIT_UP]) begin
                if (flags[BIT_TOP]) stop_motor();
                else run_motor(MODE_CODE_UP);
            end else if (flags[BIT_DOWN]) begin
                if (flags[BIT_BOTTOM]) stop_motor();
                else run_motor(MODE_CODE_DOWN);
            end else if (mode == MODE_CODE_UP) begin
                if (flags[BIT_TOP]) stop_motor();
            end else if (mode == MODE_CODE_DOWN) begin
                if (flags[BIT_BOTTOM]) stop_motor();
            end else begin
                stop_motor();
            end

            if (flags[BIT_SCREEN] && !screen_on) begin
                screen_cnt = '0;
                screen_on  = 1'b1;
            end
        end
        d.up     = (mode == MODE_CODE_UP);
        d.down   = (mode == MODE_CODE_DOWN);
        d.screen = screen_on;
        d.mode   = mode;
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_drives want;
        if (!i_rst_n) begin
            flags      = '0;
            mode       = MODE_CODE_STOP;
            motor_cnt  = '0;
            screen_on  = 1'b0;
            screen_cnt = '0;
            step_ticks = STEP_RESET;
            expected_drives_q.delete();
        end else begin
            // pop before push: a result never belongs to the item taken this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_drives_q.size() == 0) begin
                    $error("unexpected result transfer: motor_mode %0d", i_motor_mode);
                    mismatches++;
                end else begin
                    want = expected_drives_q.pop_front();
                    if (i_drive_up !== want.up) begin
                        $error("drive_up: expected %0d, got %0d", want.up, i_drive_up);
                        mismatches++;
                    end
                    if (i_drive_down !== want.down) begin
                        $error("drive_down: expected %0d, got %0d", want.down, i_drive_down);
                        mismatches++;
                    end
                    if (i_drive_screen !== want.screen) begin
                        $error("drive_screen: expected %0d, got %0d",
                               want.screen, i_drive_screen);
                        mismatches++;
                    end
                    if (i_motor_mode !== want.mode) begin
                        $error("motor_mode: expected %0d, got %0d", want.mode, i_motor_mode);
                        mismatches++;
                    end
                    drives_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) step_ticks = i_cfg_step;
            if (i_in_valid && i_in_ready) begin
                expected_drives_q.push_back(
                    apply_motor_item(i_req_type, i_first_reading, i_second_reading));
            end
        end
        o_mismatches     <= mismatches;
        o_drives_owed    <= expected_drives_q.size();
        o_drives_checked <= drives_checked;
        o_timeout_stops  <= timeout_stops;
    end

endmodule

### dv/updown_motor_timeout_controller_top_test.sv
// ----------------------------------------------------------------------------
// updown_motor_timeout_controller_top_test
// Drives sample and tick items into the motor timeout controller under a
// series of step-register settings and idling mixes; the checker beside the
// block predicts every result and reports mismatches back for the verdict.
// ----------------------------------------------------------------------------
module updown_motor_timeout_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import umtc_pkg::*;

    localparam int PHASE_ITEMS = 320;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                i_req_type       = REQ_SAMPLE;
    logic [FLAG_W-1:0]   i_first_reading  = '0;
    logic [FLAG_W-1:0]   i_second_reading = '0;
    logic                i_out_ready      = 1'b0;
    logic                i_cfg_valid      = 1'b0;
    logic [STEP_W-1:0]   i_cfg_timeout_step_ticks = STEP_RESET;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_drive_up;
    logic                o_drive_down;
    logic                o_drive_screen;
    logic [CODE_W-1:0]   o_motor_mode;
    logic                o_cfg_ready;

    int unsigned mismatches;
    int unsigned drives_owed;
    int unsigned drives_checked;
    int unsigned timeout_stops;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_kick     = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned items_sent    = 0;
    int unsigned step_writes   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    updown_motor_timeout_controller_top dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_req_type               (i_req_type),
        .i_first_reading          (i_first_reading),
        .i_second_reading         (i_second_reading),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_drive_up               (o_drive_up),
        .o_drive_down             (o_drive_down),
        .o_drive_screen           (o_drive_screen),
        .o_motor_mode             (o_motor_mode),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_timeout_step_ticks (i_cfg_timeout_step_ticks)
    );

    umtc_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_first_reading  (i_first_reading),
        .i_second_reading (i_second_reading),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_drive_up       (o_drive_up),
        .i_drive_down     (o_drive_down),
        .i_drive_screen   (o_drive_screen),
        .i_motor_mode     (o_motor_mode),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_step       (i_cfg_timeout_step_ticks),
        .o_mismatches     (mismatches),
        .o_drives_owed    (drives_owed),
        .o_drives_checked (drives_checked),
        .o_timeout_stops  (timeout_stops)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen   <= hold_kick;
            hold_left   <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // leaves at the accepting edge; the caller drives valid again in that step
    task automatic push_item(input logic kind, input logic [FLAG_W-1:0] a,
                             input logic [FLAG_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= kind;
        i_first_reading  <= a;
        i_second_reading <= b;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // only once every result is back and the pipe has drained
    task automatic write_step(input logic [STEP_W-1:0] ticks);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (drives_owed != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid              <= 1'b1;
        i_cfg_timeout_step_ticks <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        step_writes++;
    endtask

    initial begin
        logic [STEP_W-1:0] phase_steps[6];
        logic [FLAG_W-1:0] pins;
        logic [FLAG_W-1:0] first;
        logic [3:0]        sel;
        phase_steps = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd4, 16'd0};
        sel = 4'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset step value
        push_item(REQ_TICK,   9'h1FF, 9'h1FF);   // tick readings are ignored
        push_item(REQ_SAMPLE, 9'h001, 9'h001);   // up starts rising
        push_item(REQ_SAMPLE, 9'h001, 9'h001);   // held, count kept
        push_item(REQ_TICK,   9'h000, 9'h000);
        push_item(REQ_SAMPLE, 9'h000, 9'h000);   // released, travel continues
        push_item(REQ_SAMPLE, 9'h008, 9'h008);   // upper limit stops it
        push_item(REQ_SAMPLE, 9'h012, 9'h012);   // down against lower limit
        push_item(REQ_SAMPLE, 9'h002, 9'h002);   // lowering
        push_item(REQ_SAMPLE, 9'h001, 9'h001);   // reversal clears count
        push_item(REQ_SAMPLE, 9'h003, 9'h003);   // both buttons stop
        push_item(REQ_SAMPLE, 9'h1E4, 9'h0E4);   // select bounces, screen starts
        push_item(REQ_SAMPLE, 9'h001, 9'h000);   // up bounces, old flag kept
        push_item(REQ_SAMPLE, 9'h1FF, 9'h1FF);
        push_item(REQ_SAMPLE, 9'h000, 9'h000);

        // zero step: any run ends on the next tick
        write_step('0);
        push_item(REQ_SAMPLE, 9'h006, 9'h006);
        push_item(REQ_TICK,   9'h000, 9'h1FF);
        push_item(REQ_SAMPLE, 9'h000, 9'h000);

        write_step(16'd1);
        push_item(REQ_SAMPLE, 9'h005, 9'h005);   // rising and screen, select 0
        push_item(REQ_TICK,   9'h000, 9'h000);   // both time out
        push_item(REQ_SAMPLE, 9'h004, 9'h004);   // screen held restarts
        push_item(REQ_SAMPLE, 9'h1E1, 9'h1E1);   // select 15, rising
        push_item(REQ_TICK,   9'h000, 9'h000);
        push_item(REQ_SAMPLE, 9'h000, 9'h000);   // select back to 0 mid-run
        push_item(REQ_TICK,   9'h000, 9'h000);   // count already at new limit

        for (int p = 0; p < 6; p++) begin
            write_step(phase_steps[p]);
            send_idle_pct  = (p < 2) ? 12 : (p < 4) ? 59 : 0;
            recv_idle_pct <= (p < 2) ? 59 : (p < 4) ? 12 : 0;
            if (p == 4) hold_kick <= hold_kick + 1;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 55) begin
                    push_item(REQ_TICK, 9'($urandom), 9'($urandom));
                end else begin
                    // select mostly steady so runs reach their limits
                    if ($urandom_range(99) < 10) sel = 4'($urandom);
                    pins = {sel,
                            1'($urandom_range(99) < 15),    // lower limit
                            1'($urandom_range(99) < 15),    // upper limit
                            1'($urandom_range(99) < 25),    // screen
                            1'($urandom_range(99) < 30),    // down
                            1'($urandom_range(99) < 35)};   // up
                    first = pins;
                    if ($urandom_range(99) < 15) first = pins ^ 9'($urandom);
                    push_item(REQ_SAMPLE, first, pins);
                end
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (drives_owed != 0);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d sample/tick items across %0d step settings and three idling mixes.",
                 items_sent, step_writes);
        $display("Checked %0d results; %0d timeout stops were predicted.",
                 drives_checked, timeout_stops);
        if (mismatches == 0 && drives_owed == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
